@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, cond)
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

@@ rtl/sukset_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted key set package
// Widths, operation and status codes, and the per-slot control bundle.
// ----------------------------------------------------------------------------
package sukset_pkg;

   localparam int KEY_W           = 32;
   localparam int OP_W            = 2;
   localparam int STATUS_W        = 2;
   localparam int SUKSET_CAPACITY = 16;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Broadcast to every slot in the row.
   typedef struct packed {
      logic compare;    // latch compare flags against the probe key
      logic shift_up;   // insert: open a gap at the first slot not below the key
      logic shift_down; // remove: close the gap at the matched slot
   } slot_ctrl_type;

endpackage

@@ rtl/sorted_unique_key_set.sv @@
// ----------------------------------------------------------------------------
// Sorted unique key set
// Holds up to CAPACITY distinct 32-bit keys in ascending order in a row of
// slots. Each request transfer carries an opcode (insert, remove, lookup;
// code three acts as lookup) and a key; each yields one response transfer
// with a status, the matched key (zero on insert or miss) and the number of
// keys held after the operation.
// Timing: the accepting edge latches compare flags in every slot; the next
// cycle decides the outcome, shifts the row by one slot and loads the
// response register, which offers the response. A new request can be taken
// at the edge that transfers it, but not while a request is in its shift
// cycle; every request takes the compare cycle followed by the shift cycle,
// independent of fill level.
// A response held by rsp_stall keeps req_stall high until it transfers.
// Reset empties the set and drops any pending response; slot contents are
// left as they are, as only slots below the count are ever used.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_unique_key_set
   import sukset_pkg::*;
#(
   parameter  int CAPACITY = SUKSET_CAPACITY,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [KEY_W-1:0]    req_key,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [KEY_W-1:0]    rsp_matched_key,
   output logic [CNT_W-1:0]    rsp_entry_total
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [KEY_W-1:0]    matched_ff, matched_in;
   logic [CNT_W-1:0]    total_ff, total_in;

   slot_ctrl_type       ctrl;
   logic                accept;
   logic                hit;
   logic                full;
   logic [KEY_W-1:0]    slot_key [CAPACITY];
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;
   logic [CAPACITY-1:0] occ_vec;

   // Take a request only when idle and the response register will be free.
   assign req_stall = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   // The slot row: each slot sees its neighbors' keys and the left flag.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
      logic [KEY_W-1:0] left_key;
      logic             left_lt;
      logic [KEY_W-1:0] right_key;

      assign occ_vec[i] = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_first
         assign left_key = key_ff;
         assign left_lt  = 1'b1;
      end else begin : g_inner
         assign left_key = slot_key[i-1];
         assign left_lt  = lt_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = slot_key[i];
      end else begin : g_body
         assign right_key = slot_key[i+1];
      end

      sukset_slot u_slot (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occ_vec[i]),
         .probe_key (req_key),
         .new_key   (key_ff),
         .left_key  (left_key),
         .left_lt   (left_lt),
         .right_key (right_key),
         .key_out   (slot_key[i]),
         .lt_out    (lt_vec[i]),
         .eq_out    (eq_vec[i])
      );
   end

   assign hit  = |eq_vec;
   assign full = count_ff == CNT_W'(CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: held request and response fields.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      matched_ff <= matched_in;
      total_ff   <= total_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      matched_in   = matched_ff;
      total_in     = total_ff;
      ctrl         = '0;

      // Drop the response once it transfers.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.compare = 1'b1;
               op_in        = req_opcode;
               key_in       = req_key;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            matched_in = '0;
            case (op_ff)
               OP_INSERT: begin
                  if (hit) begin
                     status_in = STATUS_MISS;
                  end else if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in     = STATUS_DONE;
                     ctrl.shift_up = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  if (hit) begin
                     status_in       = STATUS_DONE;
                     matched_in      = key_ff;
                     ctrl.shift_down = 1'b1;
                     count_in        = count_ff - CNT_W'(1);
                  end else begin
                     status_in = STATUS_MISS;
                  end
               end
               default: begin
                  // Lookup, and the unused code.
                  if (hit) begin
                     status_in  = STATUS_DONE;
                     matched_in = key_ff;
                  end else begin
                     status_in = STATUS_MISS;
                  end
               end
            endcase
            total_in     = count_in;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_matched_key = matched_ff;
   assign rsp_entry_total = total_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_IMPLY(a_match_unique, clock, reset, state_ff == ST_EXEC, $onehot0(eq_vec))
   `ASSERT_IMPLY(a_below_prefix, clock, reset, state_ff == ST_EXEC, (lt_vec & (lt_vec + 1'b1)) == '0)
   `ASSERT_NEXT(a_exec_response, clock, reset, state_ff == ST_EXEC, rsp_valid_ff)

endmodule

@@ rtl/sukset_slot.sv @@
// ----------------------------------------------------------------------------
// Sorted key set slot
// One entry of the key row: holds a key, compares it against the probe key
// and shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module sukset_slot
   import sukset_pkg::*;
(
   input  logic              clock,
   input  slot_ctrl_type     ctrl,
   input  logic              occupied,
   input  logic [KEY_W-1:0]  probe_key,
   input  logic [KEY_W-1:0]  new_key,
   input  logic [KEY_W-1:0]  left_key,
   input  logic              left_lt,
   input  logic [KEY_W-1:0]  right_key,
   output logic [KEY_W-1:0]  key_out,
   output logic              lt_out,
   output logic              eq_out
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             lt_ff, lt_in;
   logic             eq_ff, eq_in;

   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      if (ctrl.compare) begin
         lt_in = occupied & (key_ff < probe_key);
         eq_in = occupied & (key_ff == probe_key);
      end
      // Slots at or above the insert point take the left neighbor; the
      // first of them takes the new key.
      if (ctrl.shift_up && !lt_ff) begin
         key_in = left_lt ? new_key : left_key;
      end
      // Slots at or above the removed key take the right neighbor.
      if (ctrl.shift_down && !lt_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule
